@@ hw/rtl/keyed_range_weight_sum_assert.svh @@
// ----------------------------------------------------------------------------
// keyed_range_weight_sum assertion macros
// clocked assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef KEYED_RANGE_WEIGHT_SUM_ASSERT_SVH
`define KEYED_RANGE_WEIGHT_SUM_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KRWS_ASSERT_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("keyed_range_weight_sum: invariant violated");
`define KRWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed_range_weight_sum: sequence violated");
`else
`define KRWS_ASSERT_NOW(lbl, expr)
`define KRWS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/krws_pkg.sv @@
// ----------------------------------------------------------------------------
// krws_pkg
// shared types and constants of the keyed range weight sum block
// ----------------------------------------------------------------------------
`default_nettype none

package krws_pkg;

  localparam int MAX_RECORDS_DEF = 1024;

  localparam int ACT_W  = 2;
  localparam int KEY_W  = 32;
  localparam int COST_W = 32;
  localparam int SUM_W  = 64;
  localparam int DIFF_W = KEY_W + 1;

  localparam int IN_FIELDS_W = ACT_W + 2 * KEY_W + COST_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = SUM_W;

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  start_key;
    logic [KEY_W-1:0]  end_key;
    logic [COST_W-1:0] cost;
  } rec_t;

  typedef struct packed {
    logic             shift;
    logic             by_start;
    logic [KEY_W-1:0] low;
    logic [KEY_W-1:0] high;
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/krws_cell.sv @@
// ----------------------------------------------------------------------------
// krws_cell
// one record slot; adds its matching contribution to the passing partial sum
// ----------------------------------------------------------------------------
`default_nettype none

module krws_cell import krws_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             ctl,
  input  logic             occupied,
  input  rec_t             rec_in,
  output rec_t             rec_out,
  input  logic [SUM_W-1:0] psum_in,
  input  logic             tok_in,
  output logic [SUM_W-1:0] psum_out,
  output logic             tok_out
);

  rec_t             rec_r;
  logic [SUM_W-1:0] psum_r;
  logic             tok_r;

  logic [KEY_W-1:0]  key;
  logic              hit;
  logic [DIFF_W-1:0] dur;
  logic [SUM_W-1:0]  contrib;
  logic [SUM_W-1:0]  psum_nxt;

  always_comb begin
    key      = ctl.by_start ? rec_r.start_key : rec_r.end_key;
    hit      = occupied && (key >= ctl.low) && (key <= ctl.high);
    dur      = {1'b0, rec_r.end_key} - {1'b0, rec_r.start_key};
    contrib  = ctl.by_start ? {{(SUM_W-COST_W){1'b0}}, rec_r.cost}
                            : {{(SUM_W-DIFF_W){dur[DIFF_W-1]}}, dur};
    psum_nxt = psum_in + (hit ? contrib : '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      rec_r <= rec_in;
    end
    psum_r <= psum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

  assign rec_out  = rec_r;
  assign psum_out = psum_r;
  assign tok_out  = tok_r;

endmodule

`default_nettype wire

@@ hw/rtl/krws_chain.sv @@
// ----------------------------------------------------------------------------
// krws_chain
// row of record cells; records shift in at the head, sums ripple to the tail
// ----------------------------------------------------------------------------
`default_nettype none

module krws_chain import krws_pkg::*; #(
  parameter int N = MAX_RECORDS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_t                     ctl,
  input  rec_t                     rec_new,
  input  logic [$clog2(N+1)-1:0]   count,
  input  logic                     tok_start,
  output logic [SUM_W-1:0]         psum_last,
  output logic                     tok_last
);

  localparam int CNT_W = $clog2(N + 1);

  rec_t             rec_link  [N+1];
  logic [SUM_W-1:0] psum_link [N+1];
  logic             tok_link  [N+1];
  logic [N-1:0]     occ;

  assign rec_link[0]  = rec_new;
  assign psum_link[0] = '0;
  assign tok_link[0]  = tok_start;

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign occ[g] = count > CNT_W'(g);

    krws_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .occupied (occ[g]),
      .rec_in   (rec_link[g]),
      .rec_out  (rec_link[g+1]),
      .psum_in  (psum_link[g]),
      .tok_in   (tok_link[g]),
      .psum_out (psum_link[g+1]),
      .tok_out  (tok_link[g+1])
    );
  end

  assign psum_last = psum_link[N];
  assign tok_last  = tok_link[N];

endmodule

`default_nettype wire

@@ hw/rtl/keyed_range_weight_sum.sv @@
// ----------------------------------------------------------------------------
// keyed_range_weight_sum
// interval record store answering range sums of costs or durations
//
//  channel | ports              | tdata                              | tuser
//  in      | in_tvalid/tready   | action, first_key, second_key, cost | query_by_start
//  out     | out_tvalid/tready  | range_sum                          | table_full
//
//  clear and add pass through S_HOLD before the next item is taken; a query waits
//  while its token walks the cell row one cell per cycle, gathering the partial sum
//  records live one per cell; an add that finds room shifts every cell along by one slot
//  reset empties the table at once, no clearing pass
//  a result waits in the output register; a new item is taken meanwhile, and
//  the next result holds in the block until the output register frees
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyed_range_weight_sum_assert.svh"

module keyed_range_weight_sum import krws_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // action[1:0], first_key[33:2], second_key[65:34], cost[97:66], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // query_by_start[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // range_sum[63:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // table_full[0]
  output logic                  out_tuser
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUERY,
    S_HOLD
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic             go_r;
  logic             by_start_r;
  logic [KEY_W-1:0] low_r;
  logic [KEY_W-1:0] high_r;
  logic [SUM_W-1:0] res_sum_r;
  logic             res_full_r;
  logic             out_tvalid_r;
  logic [SUM_W-1:0] out_tdata_r;
  logic             out_tuser_r;

  logic [ACT_W-1:0] in_action;
  rec_t             rec_new;
  logic             in_acc;
  logic             full;
  ctl_t             ctl;
  logic [SUM_W-1:0] psum_last;
  logic             tok_last;

  assign in_action         = in_tdata[ACT_W-1:0];
  assign rec_new.start_key = in_tdata[ACT_W +: KEY_W];
  assign rec_new.end_key   = in_tdata[ACT_W+KEY_W +: KEY_W];
  assign rec_new.cost      = in_tdata[ACT_W+2*KEY_W +: COST_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(MAX_RECORDS));

  assign ctl.shift    = in_acc && (in_action == ACT_ADD) && !full;
  assign ctl.by_start = by_start_r;
  assign ctl.low      = low_r;
  assign ctl.high     = high_r;

  krws_chain #(
    .N (MAX_RECORDS)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rec_new   (rec_new),
    .count     (count_r),
    .tok_start (go_r),
    .psum_last (psum_last),
    .tok_last  (tok_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      go_r         <= 1'b0;
      by_start_r   <= 1'b0;
      low_r        <= '0;
      high_r       <= '0;
      res_sum_r    <= '0;
      res_full_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
      out_tuser_r  <= 1'b0;
    end else begin
      go_r <= in_acc && (in_action == ACT_QUERY);
      if (out_tvalid_r && out_tready && (state_r != S_HOLD)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_sum_r <= '0;
            case (in_action)
              ACT_CLEAR: begin
                count_r    <= '0;
                res_full_r <= 1'b0;
                state_r    <= S_HOLD;
              end
              ACT_ADD: begin
                res_full_r <= full;
                if (!full) begin
                  count_r <= count_r + CNT_W'(1);
                end
                state_r <= S_HOLD;
              end
              ACT_QUERY: begin
                low_r      <= rec_new.start_key;
                high_r     <= rec_new.end_key;
                by_start_r <= in_tuser;
                res_full_r <= 1'b0;
                state_r    <= S_QUERY;
              end
              default: begin
                res_full_r <= 1'b0;
                state_r    <= S_HOLD;
              end
            endcase
          end
        end
        S_QUERY: begin
          if (tok_last) begin
            res_sum_r <= psum_last;
            state_r   <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= res_sum_r;
            out_tuser_r  <= res_full_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `KRWS_ASSERT_NOW(a_count_bound, count_r <= CNT_W'(MAX_RECORDS))
  `KRWS_ASSERT_NEXT(a_full_add_keeps, in_acc && (in_action == ACT_ADD) && full, $stable(count_r))
  `KRWS_ASSERT_NOW(a_tok_in_query, !tok_last || (state_r == S_QUERY))
  `KRWS_ASSERT_NOW(a_full_zero_sum, !(out_tvalid && out_tuser) || (out_tdata == '0))

endmodule

`default_nettype wire

@@ sim/krws_checker.sv @@
// ----------------------------------------------------------------------------
// krws_checker
// watches both streams of the keyed range weight sum block, keeps its own
// copy of the record store, predicts every answer and compares field by field
// ----------------------------------------------------------------------------
module krws_checker import krws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // action, first_key, second_key, cost, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // query_by_start
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // range_sum
  input  logic [OUT_DATA_W-1:0] out_tdata,
  // table_full
  input  logic                  out_tuser,
  input  logic                  end_of_test,
  output int                    fail_count,
  output int                    pending
);

  localparam int SHOWN_MAX = 40;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             full;
  } answer_t;

  rec_t        rec_store [MAX_RECORDS_DEF];
  int unsigned rec_count;
  answer_t     answer_q [$];
  int          result_idx;

  initial begin
    fail_count = 0;
    pending    = 0;
    rec_count  = 0;
    result_idx = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < SHOWN_MAX) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic answer_t predict_answer(input logic [ACT_W-1:0] act,
                                             input logic [KEY_W-1:0] lo_key,
                                             input logic [KEY_W-1:0] hi_key,
                                             input logic [COST_W-1:0] weight,
                                             input logic by_start);
    answer_t ans;
    int      i;
    ans = '0;
    case (act)
      ACT_CLEAR: begin
        rec_count = 0;
      end
      ACT_ADD: begin
        if (rec_count >= MAX_RECORDS_DEF) begin
          ans.full = 1'b1;
        end else begin
          rec_store[rec_count] = '{start_key: lo_key, end_key: hi_key, cost: weight};
          rec_count++;
        end
      end
      ACT_QUERY: begin
        for (i = 0; i < rec_count; i++) begin
          if (by_start) begin
            if (rec_store[i].start_key >= lo_key && rec_store[i].start_key <= hi_key)
              ans.sum += SUM_W'(rec_store[i].cost);
          end else if (rec_store[i].end_key >= lo_key && rec_store[i].end_key <= hi_key) begin
            // duration wraps modulo 2^64 when end lies before start
            ans.sum += SUM_W'(rec_store[i].end_key) - SUM_W'(rec_store[i].start_key);
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      rec_count = 0;
      answer_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        result_idx++;
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none outstanding", result_idx));
        end else begin
          want = answer_q.pop_front();
          if (out_tdata !== want.sum)
            report_mismatch($sformatf("result %0d range_sum got %h want %h",
                                      result_idx, out_tdata, want.sum));
          if (out_tuser !== want.full)
            report_mismatch($sformatf("result %0d table_full got %b want %b",
                                      result_idx, out_tuser, want.full));
        end
      end
      if (in_tvalid && in_tready)
        answer_q.push_back(predict_answer(in_tdata[ACT_W-1:0],
                                          in_tdata[ACT_W +: KEY_W],
                                          in_tdata[ACT_W+KEY_W +: KEY_W],
                                          in_tdata[ACT_W+2*KEY_W +: COST_W],
                                          in_tuser));
    end
    pending <= answer_q.size();
  end

  always @(posedge end_of_test) begin
    if (answer_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", answer_q.size()));
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives clears, adds, range queries and unused action codes into the keyed
// range weight sum block with random gaps on both streams, fills the store
// past capacity, and leaves all checking to krws_checker
// ----------------------------------------------------------------------------
module testbench;
  import krws_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int     HOLD_AT_RESULT = 40;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     FILL_ADDS      = MAX_RECORDS_DEF + 6;
  localparam int     MIXED_ITEMS    = 880;
  localparam longint LIMIT_TIME     = 48_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  end_of_test;
  int                    fail_count;
  int                    pending;

  logic             send_calm;
  logic             take_calm;
  logic [KEY_W-1:0] key_pool [$];
  int               n_add, n_refused, n_by_start, n_by_end, n_clear, n_unused;
  int               store_fill;

  keyed_range_weight_sum dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  krws_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .end_of_test (end_of_test),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_TIME);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return KEY_W'($urandom_range(0, 255));
      4: return 32'h7FFF_FF80 + KEY_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pool_key();
    if (key_pool.size() == 0 || $urandom_range(0, 3) == 0) return pick_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k1,
                            input logic [KEY_W-1:0] k2, input logic [COST_W-1:0] weight,
                            input logic by_start);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({weight, k2, k1, act});
    in_tuser  <= by_start;
    do @(posedge clk); while (!in_tready);
    case (act)
      ACT_CLEAR: begin
        n_clear++;
        store_fill = 0;
      end
      ACT_ADD: begin
        n_add++;
        if (store_fill >= MAX_RECORDS_DEF) n_refused++;
        else store_fill++;
        key_pool.push_back(k1);
        key_pool.push_back(k2);
        while (key_pool.size() > 64) void'(key_pool.pop_front());
      end
      ACT_QUERY: begin
        if (by_start) n_by_start++;
        else n_by_end++;
      end
      default: n_unused++;
    endcase
  endtask

  task automatic random_add();
    logic [KEY_W-1:0] k1;
    logic [KEY_W-1:0] k2;
    k1 = pick_key();
    k2 = ($urandom_range(0, 1) == 1) ? k1 + KEY_W'($urandom_range(0, 1000)) : pick_key();
    offer_item(ACT_ADD, k1, k2, pick_cost(), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_query();
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] t;
    lo = pool_key();
    hi = pool_key();
    if (lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    case ($urandom_range(0, 9))
      0: begin
        lo = '0;
        hi = '1;
      end
      1, 2: hi = lo + KEY_W'($urandom_range(0, 300));
      3: begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      4: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: ;
    endcase
    offer_item(ACT_QUERY, lo, hi, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // result side, with one long hold-off that backs the block up
  initial begin
    int gap;
    int taken;
    out_tready <= 1'b0;
    take_calm = 1'b0;
    taken     = 0;
    @(posedge clk iff rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      if (taken == HOLD_AT_RESULT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin
    int i;
    int r;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    end_of_test <= 1'b0;
    send_calm  = 1'b0;
    n_add      = 0;
    n_refused  = 0;
    n_by_start = 0;
    n_by_end   = 0;
    n_clear    = 0;
    n_unused   = 0;
    store_fill = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, extremes, wrapped durations, empty ranges
    offer_item(ACT_QUERY, '0, '1, '0, 1'b1);
    offer_item(ACT_QUERY, '0, '1, '0, 1'b0);
    offer_item(ACT_UNUSED, '1, '1, '1, 1'b1);
    offer_item(ACT_ADD, '0, '1, '1, 1'b0);
    offer_item(ACT_ADD, '1, '0, '0, 1'b1);
    offer_item(ACT_ADD, 32'd5, 32'd5, 32'd1, 1'b0);
    offer_item(ACT_ADD, 32'd100, 32'd50, 32'h8000_0000, 1'b1);
    offer_item(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, '1, 1'b0);
    offer_item(ACT_QUERY, '0, '1, '1, 1'b1);
    offer_item(ACT_QUERY, '0, '1, '1, 1'b0);
    offer_item(ACT_QUERY, 32'd5, 32'd5, '0, 1'b1);
    offer_item(ACT_QUERY, '0, '0, '0, 1'b0);
    offer_item(ACT_QUERY, '1, '1, '0, 1'b0);
    offer_item(ACT_QUERY, '1, '1, '0, 1'b1);
    offer_item(ACT_QUERY, 32'd200, 32'd100, '0, 1'b1);
    offer_item(ACT_QUERY, '1, '0, '0, 1'b0);
    offer_item(ACT_UNUSED, $urandom, $urandom, $urandom, 1'b0);
    offer_item(ACT_CLEAR, '1, '1, '1, 1'b1);
    offer_item(ACT_QUERY, '0, '1, '0, 1'b1);
    offer_item(ACT_QUERY, '0, '1, '0, 1'b0);
    offer_item(ACT_ADD, '0, '0, '0, 1'b1);
    offer_item(ACT_QUERY, '0, '0, '0, 1'b0);

    // fill the store past capacity
    offer_item(ACT_CLEAR, pick_key(), pick_key(), pick_cost(), 1'b0);
    for (i = 0; i < FILL_ADDS; i++) begin
      random_add();
      if (i % 128 == 127) random_query();
    end
    offer_item(ACT_QUERY, '0, '1, $urandom, 1'b1);
    offer_item(ACT_QUERY, '0, '1, $urandom, 1'b0);
    random_query();

    // mixed traffic
    offer_item(ACT_CLEAR, pick_key(), pick_key(), pick_cost(), 1'b1);
    for (i = 0; i < MIXED_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) offer_item(ACT_CLEAR, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      else if (r < 6) offer_item(ACT_UNUSED, $urandom, $urandom, $urandom,
                                 1'($urandom_range(0, 1)));
      else if (r < 62) random_add();
      else random_query();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (MAX_RECORDS_DEF + 16) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);

    $display("run covered %0d adds (%0d refused on a full store), %0d cost queries by start,",
             n_add, n_refused, n_by_start);
    $display("%0d duration queries by end, %0d clears and %0d items with the unused action",
             n_by_end, n_clear, n_unused);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
